/* src/tbgd_pkg.sv */
// Shared types and constants for the two-body gravity derivative pipeline.
package tbgd_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 43;
    localparam int NUM_W      = 101;
    localparam int DEN_W      = 96;
    localparam int GS_W       = 70;
    localparam int FQ_W       = 41;
    localparam int G_W        = 43;
    localparam int ACC_W      = 45;

    localparam logic [49:0] GRAV_RESET     = 50'd398600441800000;
    localparam logic [31:0] INV_MASS_RESET = 32'd4294967;
    localparam logic [19:0] GRAV_SCALE     = 20'd1000000;
    localparam logic [G_W-1:0] GRAV_CAP    = G_W'(1) << (G_W - 1);

    // register index, taken from paddr[3]
    localparam logic REG_GRAV     = 1'b0;
    localparam logic REG_INV_MASS = 1'b1;

    typedef struct packed {
        logic [2:0][31:0]      vel;
        logic [2:0]            fneg;
        logic [2:0][FQ_W-1:0]  fq;
        logic [2:0]            pneg;
        logic [2:0][NUM_W-1:0] num;
    } side_t;

    typedef struct packed {
        logic [2:0][31:0]     vel;
        logic [2:0]           fneg;
        logic [2:0][FQ_W-1:0] fq;
        logic [2:0]           pneg;
        logic                 zero_r;
        logic [2:0]           big;
        logic [DEN_W-1:0]     den;
    } dside_t;

    typedef struct packed {
        logic [DEN_W-1:0]     rem;
        logic [DIV_STEPS-1:0] low;
        logic [DIV_STEPS-1:0] quo;
    } dstate_t;

    typedef struct packed {
        logic [2:0][31:0] dvel;
        logic [2:0][31:0] accel;
        logic             err;
    } res_t;

endpackage

/* src/tbgd_prep.sv */
// Front stages: input register, magnitudes, products, sums and force term.
module tbgd_prep (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         valid_i,
    input  logic [2:0][31:0]             pos_i,
    input  logic [2:0][31:0]             vel_i,
    input  logic [2:0][31:0]             frc_i,
    input  logic [tbgd_pkg::GS_W-1:0]    grav_scaled_i,
    input  logic [31:0]                  inv_mass_i,
    output logic                         valid_o,
    output logic [63:0]                  r2_o,
    output tbgd_pkg::side_t              side_o
);

    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2:0][31:0] pos1_reg, vel1_reg, frc1_reg;
    logic [2:0][31:0] pm2_reg, fa2_reg, vel2_reg, vel3_reg;
    logic [2:0]       pneg2_reg, fneg2_reg, pneg3_reg, fneg3_reg;
    logic [2:0][63:0] sq3_reg, fm3_reg, pp0_reg, pp1_reg;
    logic [2:0][37:0] pp2_reg;
    logic [63:0]      r2_reg;
    tbgd_pkg::side_t  side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_i;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos1_reg <= pos_i;
            vel1_reg <= vel_i;
            frc1_reg <= frc_i;
            vel2_reg <= vel1_reg;
            vel3_reg <= vel2_reg;
            pneg3_reg <= pneg2_reg;
            fneg3_reg <= fneg2_reg;
            for (int i = 0; i < 3; i++) begin
                pneg2_reg[i] <= pos1_reg[i][31];
                fneg2_reg[i] <= frc1_reg[i][31];
                pm2_reg[i] <= pos1_reg[i][31] ? (~pos1_reg[i] + 32'd1) : pos1_reg[i];
                fa2_reg[i] <= frc1_reg[i][31] ? (~frc1_reg[i] + 32'd1) : frc1_reg[i];
                sq3_reg[i] <= 64'(pm2_reg[i]) * 64'(pm2_reg[i]);
                fm3_reg[i] <= 64'(fa2_reg[i]) * 64'(inv_mass_i);
                pp0_reg[i] <= 64'(grav_scaled_i[31:0]) * 64'(pm2_reg[i]);
                pp1_reg[i] <= 64'(grav_scaled_i[63:32]) * 64'(pm2_reg[i]);
                pp2_reg[i] <= 38'(grav_scaled_i[69:64]) * 38'(pm2_reg[i]);
                side_reg.num[i] <= tbgd_pkg::NUM_W'(pp0_reg[i])
                                 + (tbgd_pkg::NUM_W'(pp1_reg[i]) << 32)
                                 + (tbgd_pkg::NUM_W'(pp2_reg[i]) << 64);
                // round to nearest, ties away from zero, on the magnitude
                side_reg.fq[i] <= tbgd_pkg::FQ_W'(42'(fm3_reg[i][63:32]) * 42'd1000)
                                + tbgd_pkg::FQ_W'((43'(fm3_reg[i][31:0]) * 43'd1000
                                                   + 43'h80000000) >> 32);
            end
            r2_reg <= sq3_reg[0] + sq3_reg[1] + sq3_reg[2];
            side_reg.vel  <= vel3_reg;
            side_reg.pneg <= pneg3_reg;
            side_reg.fneg <= fneg3_reg;
        end
    end

    assign valid_o = v4_reg;
    assign r2_o    = r2_reg;
    assign side_o  = side_reg;

endmodule

/* src/tbgd_sqrt.sv */
// Integer square root, one result bit per pipeline stage.
module tbgd_sqrt (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            valid_i,
    input  logic [63:0]     r2_i,
    input  tbgd_pkg::side_t side_i,
    output logic            valid_o,
    output logic [31:0]     n_o,
    output tbgd_pkg::side_t side_o
);

    localparam int N = tbgd_pkg::SQRT_STEPS;

    logic            valid_reg [N];
    logic [63:0]     v_reg     [N];
    logic [63:0]     res_reg   [N];
    tbgd_pkg::side_t side_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic            vin;
        logic [63:0]     v_in, res_in, trial;
        tbgd_pkg::side_t s_in;

        if (k == 0) begin : g_first
            assign vin    = valid_i;
            assign v_in   = r2_i;
            assign res_in = 64'd0;
            assign s_in   = side_i;
        end else begin : g_next
            assign vin    = valid_reg[k-1];
            assign v_in   = v_reg[k-1];
            assign res_in = res_reg[k-1];
            assign s_in   = side_reg[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= s_in;
                if (v_in >= trial) begin
                    v_reg[k]   <= v_in - trial;
                    res_reg[k] <= (res_in >> 1) + BIT;
                end else begin
                    v_reg[k]   <= v_in;
                    res_reg[k] <= res_in >> 1;
                end
            end
        end
    end

    assign valid_o = valid_reg[N-1];
    assign n_o     = res_reg[N-1][31:0];
    assign side_o  = side_reg[N-1];

endmodule

/* src/tbgd_cube.sv */
// Radius cube, overflow pre-check and divider setup.
module tbgd_cube (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   valid_i,
    input  logic [31:0]            n_i,
    input  tbgd_pkg::side_t        side_i,
    output logic                   valid_o,
    output tbgd_pkg::dside_t       dside_o,
    output tbgd_pkg::dstate_t [2:0] st_o
);

    localparam int D = tbgd_pkg::DIV_STEPS;

    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic [31:0]                n1_reg;
    logic                       z1_reg, z2_reg, z3_reg;
    logic [63:0]                nn1_reg, plo2_reg, phi2_reg;
    logic [tbgd_pkg::DEN_W-1:0] den3_reg;
    tbgd_pkg::side_t            s1_reg, s2_reg, s3_reg;
    tbgd_pkg::dside_t           ds_reg;
    tbgd_pkg::dstate_t [2:0]    st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_i;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nn1_reg  <= 64'(n_i) * 64'(n_i);
            n1_reg   <= n_i;
            z1_reg   <= (n_i == 32'd0);
            s1_reg   <= side_i;
            plo2_reg <= 64'(nn1_reg[31:0]) * 64'(n1_reg);
            phi2_reg <= 64'(nn1_reg[63:32]) * 64'(n1_reg);
            z2_reg   <= z1_reg;
            s2_reg   <= s1_reg;
            den3_reg <= (tbgd_pkg::DEN_W'(phi2_reg) << 32) + tbgd_pkg::DEN_W'(plo2_reg);
            z3_reg   <= z2_reg;
            s3_reg   <= s2_reg;
            ds_reg.vel    <= s3_reg.vel;
            ds_reg.fneg   <= s3_reg.fneg;
            ds_reg.fq     <= s3_reg.fq;
            ds_reg.pneg   <= s3_reg.pneg;
            ds_reg.zero_r <= z3_reg;
            ds_reg.den    <= den3_reg;
            for (int i = 0; i < 3; i++) begin
                // quotient reaches 2^43 or more: the divider result is ignored, result capped
                ds_reg.big[i] <= tbgd_pkg::DEN_W'(s3_reg.num[i][tbgd_pkg::NUM_W-1:D])
                                 >= den3_reg;
                st_reg[i].rem <= tbgd_pkg::DEN_W'(s3_reg.num[i][tbgd_pkg::NUM_W-1:D]);
                st_reg[i].low <= s3_reg.num[i][D-1:0];
                st_reg[i].quo <= '0;
            end
        end
    end

    assign valid_o = v4_reg;
    assign dside_o = ds_reg;
    assign st_o    = st_reg;

endmodule

/* src/tbgd_div.sv */
// Restoring divide, one quotient bit per stage, three axes in parallel.
module tbgd_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    valid_i,
    input  tbgd_pkg::dside_t        dside_i,
    input  tbgd_pkg::dstate_t [2:0] st_i,
    output logic                    valid_o,
    output tbgd_pkg::dside_t        dside_o,
    output tbgd_pkg::dstate_t [2:0] st_o
);

    localparam int N  = tbgd_pkg::DIV_STEPS;
    localparam int DW = tbgd_pkg::DEN_W;

    logic                    valid_reg [N];
    tbgd_pkg::dside_t        ds_reg    [N];
    tbgd_pkg::dstate_t [2:0] st_reg    [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic                    vin;
        tbgd_pkg::dside_t        d_in;
        tbgd_pkg::dstate_t [2:0] s_in;
        tbgd_pkg::dstate_t [2:0] s_nx;

        if (k == 0) begin : g_first
            assign vin  = valid_i;
            assign d_in = dside_i;
            assign s_in = st_i;
        end else begin : g_next
            assign vin  = valid_reg[k-1];
            assign d_in = ds_reg[k-1];
            assign s_in = st_reg[k-1];
        end

        always_comb begin
            logic [DW:0] sh;
            logic        ge;
            for (int i = 0; i < 3; i++) begin
                sh = {s_in[i].rem, s_in[i].low[N-1]};
                ge = sh >= {1'b0, d_in.den};
                s_nx[i].rem = ge ? DW'(sh - {1'b0, d_in.den}) : sh[DW-1:0];
                s_nx[i].low = s_in[i].low << 1;
                s_nx[i].quo = {s_in[i].quo[N-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ds_reg[k] <= d_in;
                st_reg[k] <= s_nx;
            end
        end
    end

    assign valid_o = valid_reg[N-1];
    assign dside_o = ds_reg[N-1];
    assign st_o    = st_reg[N-1];

endmodule

/* src/tbgd_out.sv */
// Final sum and saturation stage followed by a two-entry output buffer.
module tbgd_out (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    valid_i,
    input  tbgd_pkg::dside_t        dside_i,
    input  tbgd_pkg::dstate_t [2:0] st_i,
    input  logic                    m_ready,
    output logic                    m_valid,
    output tbgd_pkg::res_t          res_o,
    output logic                    en
);

    localparam int AW = tbgd_pkg::ACC_W;
    localparam logic signed [AW-1:0] ACC_MAX = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] ACC_MIN = AW'(-64'sd2147483648);

    logic           fin_valid_reg;
    tbgd_pkg::res_t fin_reg, fin_next;
    tbgd_pkg::res_t buf_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push, pop;

    always_comb begin
        logic [tbgd_pkg::G_W-1:0] g;
        logic signed [AW-1:0]     fs, gt, acc;
        fin_next.dvel = dside_i.vel;
        fin_next.err  = dside_i.zero_r;
        for (int i = 0; i < 3; i++) begin
            if (dside_i.zero_r) begin
                g = '0;
            end else if (dside_i.big[i] || (st_i[i].quo > tbgd_pkg::DIV_STEPS'(tbgd_pkg::GRAV_CAP))) begin
                g = tbgd_pkg::GRAV_CAP;
            end else begin
                g = st_i[i].quo;
            end
            fs  = $signed(AW'(dside_i.fq[i]));
            fs  = dside_i.fneg[i] ? -fs : fs;
            gt  = $signed(AW'(g));
            gt  = dside_i.pneg[i] ? gt : -gt;
            acc = fs + gt;
            if (acc > ACC_MAX) begin
                fin_next.accel[i] = 32'h7FFFFFFF;
                fin_next.err = 1'b1;
            end else if (acc < ACC_MIN) begin
                fin_next.accel[i] = 32'h80000000;
                fin_next.err = 1'b1;
            end else begin
                fin_next.accel[i] = acc[31:0];
            end
        end
    end

    assign en   = (count_reg != 2'd2);
    assign push = en && fin_valid_reg;
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
        end else begin
            if (en) begin
                fin_valid_reg <= valid_i;
            end
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_reg <= fin_next;
        end
        if (push) begin
            buf_reg[wr_ptr_reg] <= fin_reg;
        end
    end

    assign m_valid = (count_reg != 2'd0);
    assign res_o   = buf_reg[rd_ptr_reg];

endmodule

/* src/two_body_gravity_derivative.sv */
// Two-body point-mass gravity derivative: top level with APB register port.
// Structure: from the accepting edge to m_valid the data passes 85 register stages
// (4 front, 32 square root, 4 cube, 43 divide, 1 sum, 1 output buffer).
// Throughput: one transaction per cycle; the whole pipeline advances together
// and holds only when the two-entry output buffer is full.
// Reset (aresetn low, synchronous): pipeline and buffer empty, registers at
// grav_param = 398600441800000 and inv_mass = 4294967.
module two_body_gravity_derivative (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pos_x,
    input  logic [31:0] s_pos_y,
    input  logic [31:0] s_pos_z,
    input  logic [31:0] s_vel_x,
    input  logic [31:0] s_vel_y,
    input  logic [31:0] s_vel_z,
    input  logic [31:0] s_force_x,
    input  logic [31:0] s_force_y,
    input  logic [31:0] s_force_z,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_dvel_x,
    output logic [31:0] m_dvel_y,
    output logic [31:0] m_dvel_z,
    output logic [31:0] m_accel_x,
    output logic [31:0] m_accel_y,
    output logic [31:0] m_accel_z,
    output logic        m_range_error
);

    // Registers. grav_scaled_reg holds grav_param * 10^6 and follows the register in the
    // next cycle; writes must come only while idle, and the block does not enforce this.
    logic [49:0]                grav_param_reg;
    logic [31:0]                inv_mass_reg;
    logic [tbgd_pkg::GS_W-1:0]  grav_scaled_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_param_reg  <= tbgd_pkg::GRAV_RESET;
            inv_mass_reg    <= tbgd_pkg::INV_MASS_RESET;
            grav_scaled_reg <= tbgd_pkg::GS_W'(tbgd_pkg::GRAV_RESET)
                             * tbgd_pkg::GS_W'(tbgd_pkg::GRAV_SCALE);
        end else begin
            grav_scaled_reg <= tbgd_pkg::GS_W'(grav_param_reg)
                             * tbgd_pkg::GS_W'(tbgd_pkg::GRAV_SCALE);
            if (wr_en) begin
                unique case (paddr[3])
                    tbgd_pkg::REG_GRAV:     grav_param_reg <= pwdata[49:0];
                    tbgd_pkg::REG_INV_MASS: inv_mass_reg   <= pwdata[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[3])
            tbgd_pkg::REG_GRAV:     prdata = 64'(grav_param_reg);
            tbgd_pkg::REG_INV_MASS: prdata = 64'(inv_mass_reg);
            default:                prdata = '0;
        endcase
    end

    // Shared pipeline advance: every stage moves when the output buffer has room.
    logic                    en;
    logic                    pv, sv, cv, dv;
    logic [63:0]             r2;
    logic [31:0]             n;
    tbgd_pkg::side_t         pside, sside;
    tbgd_pkg::dside_t        cds, dds;
    tbgd_pkg::dstate_t [2:0] cst, dst;
    tbgd_pkg::res_t          res;

    assign s_ready = en;

    // magnitudes, squares, mu*1e6*|r_i| and the force term
    tbgd_prep u_prep (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .valid_i       (s_valid),
        .pos_i         ({s_pos_z, s_pos_y, s_pos_x}),
        .vel_i         ({s_vel_z, s_vel_y, s_vel_x}),
        .frc_i         ({s_force_z, s_force_y, s_force_x}),
        .grav_scaled_i (grav_scaled_reg),
        .inv_mass_i    (inv_mass_reg),
        .valid_o       (pv),
        .r2_o          (r2),
        .side_o        (pside)
    );

    // |r| = floor(sqrt(r2))
    tbgd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (pv),
        .r2_i    (r2),
        .side_i  (pside),
        .valid_o (sv),
        .n_o     (n),
        .side_o  (sside)
    );

    // |r|^3 and early detection of quotients of 2^43 or more, past the 2^42 clamp
    tbgd_cube u_cube (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (sv),
        .n_i     (n),
        .side_i  (sside),
        .valid_o (cv),
        .dside_o (cds),
        .st_o    (cst)
    );

    // remaining 43 quotient bits of mu*1e6*|r_i| / |r|^3
    tbgd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (cv),
        .dside_i (cds),
        .st_i    (cst),
        .valid_o (dv),
        .dside_o (dds),
        .st_o    (dst)
    );

    // sign, sum, saturation, error flag and output buffering
    tbgd_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid_i (dv),
        .dside_i (dds),
        .st_i    (dst),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .res_o   (res),
        .en      (en)
    );

    assign m_dvel_x      = res.dvel[0];
    assign m_dvel_y      = res.dvel[1];
    assign m_dvel_z      = res.dvel[2];
    assign m_accel_x     = res.accel[0];
    assign m_accel_y     = res.accel[1];
    assign m_accel_z     = res.accel[2];
    assign m_range_error = res.err;

endmodule

/* verif/tb_two_body_gravity_derivative.sv */
// Testbench for the two-body gravity derivative pipeline: directed and random states.
`timescale 1ns / 100ps

module tb_two_body_gravity_derivative;

    // state vector handed to the block in one transaction
    typedef struct {
        logic [31:0] pos [3];
        logic [31:0] vel [3];
        logic [31:0] frc [3];
    } sc_state_t;

    // derivative returned by the block
    typedef struct {
        logic [31:0] dvel [3];
        logic [31:0] accel [3];
        logic        err;
    } sc_deriv_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic [31:0] s_vel_x = '0, s_vel_y = '0, s_vel_z = '0;
    logic [31:0] s_force_x = '0, s_force_y = '0, s_force_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_dvel_x, m_dvel_y, m_dvel_z;
    logic [31:0] m_accel_x, m_accel_y, m_accel_z;
    logic        m_range_error;

    two_body_gravity_derivative u_dut (.*);

    always #5 aclk = ~aclk;

    // predictor's copy of the registers
    logic [49:0] mu_q;
    logic [31:0] imass_q;

    sc_state_t  pending_states [$];
    sc_deriv_t  expected_derivs [$];
    int         n_errors = 0;
    int         n_checked = 0;
    int         n_sent = 0;
    int         n_saturated = 0;

    // idle controls: rates are in percent
    int  send_idle_pct = 6;
    int  recv_idle_pct = 6;
    bit  recv_holdoff = 1'b0;
    bit  send_pause = 1'b0;

    // floor square root by the 32-step digit method
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // derivative of one state under the current mu and 1/mass
    function automatic sc_deriv_t gravity_derivative(input sc_state_t st);
        sc_deriv_t        d;
        logic signed [63:0] p [3];
        logic signed [63:0] f [3];
        logic [63:0]      pm [3];
        logic [63:0]      r2;
        logic [63:0]      n;
        logic [127:0]     den;
        logic [127:0]     num;
        logic [127:0]     quo;
        logic [63:0]      fm;
        logic [63:0]      fq;
        logic [63:0]      g;
        logic signed [63:0] acc;
        r2 = '0;
        d.err = 1'b0;
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(st.pos[i]);
            f[i] = $signed(st.frc[i]);
            pm[i] = p[i] < 0 ? -p[i] : p[i];
            r2 += pm[i] * pm[i];
            d.dvel[i] = st.vel[i];
        end
        n = isqrt(r2);
        den = 128'(n) * 128'(n) * 128'(n);
        if (n == 0)
            d.err = 1'b1;
        for (int i = 0; i < 3; i++) begin
            fm = (f[i] < 0 ? -f[i] : f[i]) * 64'(imass_q);
            fq = (fm >> 32) * 1000 + (((fm & 64'hFFFF_FFFF) * 1000 + 64'h8000_0000) >> 32);
            acc = f[i] < 0 ? -$signed(fq) : $signed(fq);
            if (n != 0 && pm[i] != 0) begin
                num = 128'(mu_q) * 128'(pm[i]) * 128'd1000000;
                quo = num / den;
                // gravity term clamped well outside the output range
                g = quo > (128'd1 << 42) ? (64'd1 << 42) : quo[63:0];
                acc = p[i] < 0 ? acc + $signed(g) : acc - $signed(g);
            end
            if (acc > 64'sd2147483647) begin
                acc = 64'sd2147483647;
                d.err = 1'b1;
            end else if (acc < -64'sd2147483648) begin
                acc = -64'sd2147483648;
                d.err = 1'b1;
            end
            d.accel[i] = acc[31:0];
        end
        return d;
    endfunction

    // driver: one transaction offered per cycle unless idling or held by s_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                n_sent <= n_sent + 1;
            if (pending_states.size() > 0 && !send_pause &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                sc_state_t st;
                st = pending_states.pop_front();
                expected_derivs.push_back(gravity_derivative(st));
                s_pos_x <= st.pos[0]; s_pos_y <= st.pos[1]; s_pos_z <= st.pos[2];
                s_vel_x <= st.vel[0]; s_vel_y <= st.vel[1]; s_vel_z <= st.vel[2];
                s_force_x <= st.frc[0]; s_force_y <= st.frc[1]; s_force_z <= st.frc[2];
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each accepted result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= !recv_holdoff && ($urandom_range(99, 0) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (expected_derivs.size() == 0) begin
                    $display("%0t: result with nothing expected, accel %h %h %h", $time,
                             m_accel_x, m_accel_y, m_accel_z);
                    n_errors++;
                end else begin
                    sc_deriv_t e;
                    logic [31:0] got_v [3];
                    logic [31:0] got_a [3];
                    e = expected_derivs.pop_front();
                    got_v = '{m_dvel_x, m_dvel_y, m_dvel_z};
                    got_a = '{m_accel_x, m_accel_y, m_accel_z};
                    for (int i = 0; i < 3; i++) begin
                        if (got_v[i] !== e.dvel[i]) begin
                            $display("%0t: dvel[%0d] expected %h actual %h", $time, i,
                                     e.dvel[i], got_v[i]);
                            n_errors++;
                        end
                        if (got_a[i] !== e.accel[i]) begin
                            $display("%0t: accel[%0d] expected %h actual %h", $time, i,
                                     e.accel[i], got_a[i]);
                            n_errors++;
                        end
                    end
                    if (m_range_error !== e.err) begin
                        $display("%0t: range_error expected %b actual %b", $time, e.err,
                                 m_range_error);
                        n_errors++;
                    end
                    if (e.err)
                        n_saturated++;
                    n_checked++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_axis(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(2000, 0) - 1000;
            2: return 32'(int'($urandom_range(200000, 0)) - 100000) * 100;
            default: return $urandom() >>> $urandom_range(31, 0);
        endcase
    endfunction

    function automatic sc_state_t rand_state();
        sc_state_t st;
        int mode;
        mode = $urandom_range(3, 0);
        for (int i = 0; i < 3; i++) begin
            // mostly orbit-like radii, a few wild or tiny ones
            case ($urandom_range(9, 0))
                0: st.pos[i] = $urandom();
                1: st.pos[i] = $urandom_range(8, 0) - 4;
                2: st.pos[i] = '0;
                default: st.pos[i] = 32'(int'($urandom_range(14000000, 0)) - 7000000);
            endcase
            st.vel[i] = $urandom();
            st.frc[i] = rand_axis(mode);
        end
        return st;
    endfunction

    function automatic sc_state_t make_state(input logic [31:0] px, py, pz, fx, fy, fz);
        sc_state_t st;
        st.pos = '{px, py, pz};
        st.vel = '{$urandom(), $urandom(), $urandom()};
        st.frc = '{fx, fy, fz};
        return st;
    endfunction

    task automatic apb_write(input logic reg_idx, input logic [63:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {reg_idx, 3'b000}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (reg_idx == tbgd_pkg::REG_GRAV)
            mu_q = val[49:0];
        else
            imass_q = val[31:0];
    endtask

    // block until all in-flight transactions have come back, then let the pipe drain
    task automatic wait_drained();
        while (pending_states.size() > 0 || s_valid || expected_derivs.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++)
            pending_states.push_back(rand_state());
    endtask

    initial begin
        logic [31:0] mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7FFF_FFFF;
        mu_q = tbgd_pkg::GRAV_RESET;
        imass_q = tbgd_pkg::INV_MASS_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero radius, extremes, single axes, sign combinations
        pending_states.push_back(make_state(0, 0, 0, 0, 0, 0));
        pending_states.push_back(make_state(0, 0, 0, mx, mn, 1));
        pending_states.push_back(make_state(mn, mn, mn, mx, mx, mx));
        pending_states.push_back(make_state(mx, mx, mx, mn, mn, mn));
        pending_states.push_back(make_state(mn, 0, 0, 0, 0, 0));
        pending_states.push_back(make_state(1, 0, 0, 0, 0, 0));
        pending_states.push_back(make_state(0, -1, 0, 5, -5, 0));
        pending_states.push_back(make_state(0, 0, 6378137, 1000, 0, -1000));
        pending_states.push_back(make_state(-6778000, 0, 0, 0, 0, 0));
        pending_states.push_back(make_state(4000000, -4000000, 3000000, -1, 1, 0));
        pending_states.push_back(make_state(1, 1, 1, mn, mx, 0));
        pending_states.push_back(make_state(42164000, 0, 0, 7, 8, 9));
        wait_drained();

        // extreme registers: maximum mu and 1/mass
        apb_write(tbgd_pkg::REG_GRAV, 64'h3_FFFF_FFFF_FFFF);
        apb_write(tbgd_pkg::REG_INV_MASS, 64'hFFFF_FFFF);
        pending_states.push_back(make_state(mx, mx, mx, mx, mn, mx));
        pending_states.push_back(make_state(100000, 0, 0, 1000, -1000, 0));
        run_random(150);
        wait_drained();

        // smallest register values
        apb_write(tbgd_pkg::REG_GRAV, 64'd1);
        apb_write(tbgd_pkg::REG_INV_MASS, 64'd1);
        pending_states.push_back(make_state(1, 0, 0, 1, -1, mx));
        pending_states.push_back(make_state(mn, mx, 0, mn, 0, 0));
        run_random(150);
        wait_drained();

        // back to nominal Earth values; long stall on the result side
        apb_write(tbgd_pkg::REG_GRAV, 64'(tbgd_pkg::GRAV_RESET));
        apb_write(tbgd_pkg::REG_INV_MASS, 64'(tbgd_pkg::INV_MASS_RESET));
        run_random(300);
        recv_holdoff = 1'b1;
        repeat (300) @(posedge aclk);
        recv_holdoff = 1'b0;
        // stretch with no idling on either side
        while (pending_states.size() > 0) @(posedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(300);
        while (pending_states.size() > 0) @(posedge aclk);
        send_idle_pct = 6;
        recv_idle_pct = 6;
        // sender pauses until everything is back
        send_pause = 1'b1;
        while (expected_derivs.size() > 0) @(posedge aclk);
        send_pause = 1'b0;

        // random register values
        apb_write(tbgd_pkg::REG_GRAV,
                  {14'd0, 50'($urandom_range(1000000, 1)) * 50'd1000000000});
        apb_write(tbgd_pkg::REG_INV_MASS, 64'($urandom_range(32'hFFFF_FFFF, 1)));
        run_random(400);
        wait_drained();
        apb_write(tbgd_pkg::REG_GRAV, 64'd398600441800000);
        apb_write(tbgd_pkg::REG_INV_MASS, 64'd42949673);
        run_random(400);
        wait_drained();

        $display("Checked %0d state derivatives, %0d flagged range errors, over six register",
                 n_checked, n_saturated);
        $display("settings with output stalls, input gaps and back-to-back streams.");
        if (n_errors == 0 && expected_derivs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
